>>> rtl/bilinear_texture_sampler_top_macros.svh
// Assertion helpers shared by the sampler RTL.
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BTS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define BTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/bts_pkg.sv
`timescale 1ns / 1ps
package bts_pkg;

	localparam int MAX_TEX_WIDTH  = 256;
	localparam int MAX_TEX_HEIGHT = 256;

	// index widths for one column or row
	localparam int XB = $clog2(MAX_TEX_WIDTH);
	localparam int YB = $clog2(MAX_TEX_HEIGHT);

	// store split into four banks by column and row parity
	localparam int NUM_BANKS = 4;
	localparam int BANK_AW   = (XB - 1) + (YB - 1);

	localparam int FRAC_BITS = 16;
	localparam int UNIT_W    = FRAC_BITS + 1;
	localparam logic [UNIT_W-1:0] COORD_ONE = UNIT_W'(1 << FRAC_BITS);

	localparam int COORD_W = 18;
	localparam int CFG_W   = 9;
	localparam int TEXEL_W = 32;
	localparam int CHAN_W  = 8;
	localparam int NUM_CH  = 4;

	typedef logic [TEXEL_W-1:0] texel_t;

	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_type_t;

	typedef enum logic {
		REG_TEX_WIDTH  = 1'b0,
		REG_TEX_HEIGHT = 1'b1
	} reg_index_t;

endpackage

>>> rtl/bts_ram.sv
`timescale 1ns / 1ps
module bts_ram #(
	parameter int AW = 14,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [1 << AW];

	// a read and a write to the same entry in the same cycle return the old data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/bilinear_texture_sampler_top.sv
`timescale 1ns / 1ps
// Bilinear RGBA8 texture sampler with clamp-to-edge addressing. busy stays low: one
// transaction (texel write or sample) is taken in every clock cycle, since the texel
// store is split into four banks by column and row parity so that the four neighbors
// of a sample are read in the same cycle, one port per bank. A write lands in the store at
// its accept edge, so any later sample sees it. A sample's result pulses on
// sample_valid for one cycle, once its valid bit has passed valid_s1, valid_s2 and valid_s3;
// results come out in order and cannot be held off. Writes give no result.
// tex_width and tex_height (0 acts as 1, above 256 as 256) may be written only while
// no sample is in flight. The store holds no defined data until written.
module bilinear_texture_sampler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [7:0]                      texel_x,
	input  logic [7:0]                      texel_y,
	input  logic [bts_pkg::TEXEL_W-1:0]     texel_rgba,
	input  logic signed [bts_pkg::COORD_W-1:0] u_coord,
	input  logic signed [bts_pkg::COORD_W-1:0] v_coord,
	output logic                            sample_valid,
	output logic [bts_pkg::TEXEL_W-1:0]     sample_rgba,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [bts_pkg::CFG_W-1:0]       cfg_data
);
	import bts_pkg::*;

	localparam int PXW = UNIT_W + XB;
	localparam int PYW = UNIT_W + YB;
	localparam int BLW = 26;
	localparam int CVW = 42;

	logic          acc_wr, acc_smp;
	logic [XB-1:0] wm1_q;
	logic [YB-1:0] hm1_q;

	logic [UNIT_W-1:0] u_cl, v_cl, v_flip;
	logic              valid_s1;
	logic [PXW-1:0]    px_s1;
	logic [PYW-1:0]    py_s1;

	logic [XB-1:0]  x0, x1;
	logic [YB-1:0]  y0, y1;
	logic [XB:0]    x0_raw;
	logic [YB:0]    y0_raw;

	logic                 valid_s2;
	logic [FRAC_BITS-1:0] tx_s2, ty_s2;
	logic                 x0p_s2, x1p_s2, y0p_s2, y1p_s2;
	texel_t               bank_rd_s2 [NUM_BANKS];

	logic                 wr_in_range;
	logic [1:0]           wr_bank;
	logic [BANK_AW-1:0]   wr_addr;
	logic [XB-1:0]        wx;
	logic [YB-1:0]        wy;

	texel_t t00, t10, t01, t11;
	logic [23:0] r0_c [NUM_CH];
	logic [23:0] r1_c [NUM_CH];
	logic                 valid_s3;
	logic [23:0]          r0_s3 [NUM_CH];
	logic [23:0]          r1_s3 [NUM_CH];
	logic [FRAC_BITS-1:0] ty_s3;

	texel_t rgba_c;

	assign busy = 1'b0;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= XB'(MAX_TEX_WIDTH - 1);
			hm1_q <= YB'(MAX_TEX_HEIGHT - 1);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TEX_WIDTH: begin
					if (cfg_data == '0) wm1_q <= '0;
					else if (int'(cfg_data) > MAX_TEX_WIDTH) wm1_q <= XB'(MAX_TEX_WIDTH - 1);
					else wm1_q <= XB'(cfg_data - CFG_W'(1));
				end
				REG_TEX_HEIGHT: begin
					if (cfg_data == '0) hm1_q <= '0;
					else if (int'(cfg_data) > MAX_TEX_HEIGHT) hm1_q <= YB'(MAX_TEX_HEIGHT - 1);
					else hm1_q <= YB'(cfg_data - CFG_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- accept and scale ----------------
	assign wr_in_range = (int'(texel_x) < MAX_TEX_WIDTH) && (int'(texel_y) < MAX_TEX_HEIGHT);
	assign acc_wr  = start && !busy && (req_type_t'(req_type) == REQ_WRITE) && wr_in_range;
	assign acc_smp = start && !busy && (req_type_t'(req_type) == REQ_SAMPLE);

	always_comb begin
		if (u_coord[COORD_W-1]) u_cl = '0;
		else if (u_coord[UNIT_W-1:0] > COORD_ONE) u_cl = COORD_ONE;
		else u_cl = u_coord[UNIT_W-1:0];
		if (v_coord[COORD_W-1]) v_cl = '0;
		else if (v_coord[UNIT_W-1:0] > COORD_ONE) v_cl = COORD_ONE;
		else v_cl = v_coord[UNIT_W-1:0];
		v_flip = COORD_ONE - v_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc_smp;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= PXW'(u_cl) * PXW'(wm1_q);
		py_s1 <= PYW'(v_flip) * PYW'(hm1_q);
	end

	// ---------------- neighbor addresses ----------------
	always_comb begin
		x0_raw = px_s1[PXW-1:FRAC_BITS];
		y0_raw = py_s1[PYW-1:FRAC_BITS];
		x0 = (x0_raw > {1'b0, wm1_q}) ? wm1_q : x0_raw[XB-1:0];
		y0 = (y0_raw > {1'b0, hm1_q}) ? hm1_q : y0_raw[YB-1:0];
		// clamp the +1 neighbor to the last column or row
		x1 = (x0 == wm1_q) ? x0 : x0 + 1'b1;
		y1 = (y0 == hm1_q) ? y0 : y0 + 1'b1;
	end

	// ---------------- banked texel store ----------------
	assign wx      = XB'(texel_x);
	assign wy      = YB'(texel_y);
	assign wr_bank = {wy[0], wx[0]};
	assign wr_addr = {wy[YB-1:1], wx[XB-1:1]};

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam bit BX = (b % 2) == 1;
		localparam bit BY = (b / 2) == 1;
		logic [XB-2:0]      rcol;
		logic [YB-2:0]      rrow;
		logic               bwe;

		assign rcol = (x0[0] == BX) ? x0[XB-1:1] : x1[XB-1:1];
		assign rrow = (y0[0] == BY) ? y0[YB-1:1] : y1[YB-1:1];
		assign bwe  = acc_wr && (wr_bank == 2'(b));

		bts_ram #(
			.AW(BANK_AW),
			.DW(TEXEL_W)
		) u_ram (
			.clk  (clk),
			.we   (bwe),
			.waddr(wr_addr),
			.wdata(texel_rgba),
			.re   (valid_s1),
			.raddr({rrow, rcol}),
			.rdata(bank_rd_s2[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tx_s2  <= px_s1[FRAC_BITS-1:0];
		ty_s2  <= py_s1[FRAC_BITS-1:0];
		x0p_s2 <= x0[0];
		x1p_s2 <= x1[0];
		y0p_s2 <= y0[0];
		y1p_s2 <= y1[0];
	end

	// ---------------- horizontal blend ----------------
	always_comb begin
		logic signed [CHAN_W:0]    da, dd;
		logic signed [BLW-1:0]     pa, pd, sa, sd;
		t00 = bank_rd_s2[{y0p_s2, x0p_s2}];
		t10 = bank_rd_s2[{y0p_s2, x1p_s2}];
		t01 = bank_rd_s2[{y1p_s2, x0p_s2}];
		t11 = bank_rd_s2[{y1p_s2, x1p_s2}];
		for (int c = 0; c < NUM_CH; c++) begin
			// a*(1-t) + b*t as a + (b-a)*t
			da = $signed({1'b0, t10[c*CHAN_W +: CHAN_W]}) -
				$signed({1'b0, t00[c*CHAN_W +: CHAN_W]});
			dd = $signed({1'b0, t11[c*CHAN_W +: CHAN_W]}) -
				$signed({1'b0, t01[c*CHAN_W +: CHAN_W]});
			pa = BLW'(da * $signed({1'b0, tx_s2}));
			pd = BLW'(dd * $signed({1'b0, tx_s2}));
			sa = $signed({2'b0, t00[c*CHAN_W +: CHAN_W], 16'b0}) + pa;
			sd = $signed({2'b0, t01[c*CHAN_W +: CHAN_W], 16'b0}) + pd;
			r0_c[c] = sa[23:0];
			r1_c[c] = sd[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		r0_s3 <= r0_c;
		r1_s3 <= r1_c;
		ty_s3 <= ty_s2;
	end

	// ---------------- vertical blend, round, saturate ----------------
	always_comb begin
		logic signed [24:0]    dr;
		logic signed [CVW-1:0] pr, cv;
		logic [CVW-33:0]       q;
		rgba_c = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			dr = $signed({1'b0, r1_s3[c]}) - $signed({1'b0, r0_s3[c]});
			pr = CVW'(dr * $signed({1'b0, ty_s3}));
			cv = $signed({2'b0, r0_s3[c], 16'b0}) + pr + CVW'(64'h8000_0000);
			q  = cv[CVW-1:32];
			rgba_c[c*CHAN_W +: CHAN_W] = (q > 10'd255) ? 8'hFF : q[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			sample_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sample_rgba <= rgba_c;
	end

	// ---------------- checks ----------------
`include "bilinear_texture_sampler_top_macros.svh"

	`BTS_ASSERT(a_sample_latency, sample_valid == $past(valid_s1, 3), "result strobe out of step")
	`BTS_ASSERT_IMP(a_nbr_in_range, valid_s1, (x1 <= wm1_q) && (y1 <= hm1_q), "neighbor past edge")
	`BTS_ASSERT_IMP(a_x_edge_clamp, valid_s1, (x1 == x0) == (x0 == wm1_q), "column clamp wrong")
	`BTS_ASSERT_IMP(a_y_edge_clamp, valid_s1, (y1 == y0) == (y0 == hm1_q), "row clamp wrong")

endmodule
